### rtl/npcs_pkg.sv
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared constants and types of the nearest palette color search unit.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int CH_W          = 8;
    localparam int COLOR_W       = 3 * CH_W;
    localparam int DIST_W        = 18;
    localparam int CFG_W         = 9;
    localparam int IDX_OUT_W     = 8;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [ADDR_W-1:0] idx;
    } t_tag;

    typedef struct packed {
        t_tag              tag;
        logic [DIST_W-1:0] sum;
    } t_dist;

endpackage

### rtl/nearest_palette_color_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// Finds the palette entry closest to an RGB color (squared distance).
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A write item
//   (action 0) stores red/green/blue at entry_index, gives no result
//   and leaves busy low; indexes beyond the palette are dropped.
//   A map item (action 1) scans entries 0..count-1, count being
//   palette_count clamped to the palette depth, one entry per cycle from
//   the palette RAM through a shared two-stage distance unit.
//   Entries pass the RAM read register and both distance stages; busy
//   stays high until the last one is compared, so no new item is taken
//   before the result. An empty palette returns index 0, distance 0 in
//   the cycle after acceptance without raising busy.
//   The result is on o_best_index/o_best_distance in the cycle
//   o_valid is high; the receiver cannot stall.
//   The user must write palette_count through i_cfg_we/i_cfg_data only
//   while idle; the block does not enforce it. Reset clears the count and
//   all control state; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit
    import npcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_action,
    input  logic [7:0]           i_entry_index,
    input  logic [CH_W-1:0]      i_red,
    input  logic [CH_W-1:0]      i_green,
    input  logic [CH_W-1:0]      i_blue,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    output logic [IDX_OUT_W-1:0] o_best_index,
    output logic [DIST_W-1:0]    o_best_distance
);

    logic                 r_busy;
    logic                 r_issue;
    logic [CNT_W-1:0]     r_addr;
    logic [CNT_W-1:0]     r_count;
    logic [COLOR_W-1:0]   r_color;
    t_tag                 r_rd_tag;
    logic [DIST_W-1:0]    r_best_dist;
    logic [ADDR_W-1:0]    r_best_idx;
    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [DIST_W-1:0]    r_out_dist;

    logic [CNT_W-1:0]     n_addr;
    logic                 n_last;
    logic                 n_take;
    logic [DIST_W-1:0]    n_best_dist;
    logic [ADDR_W-1:0]    n_best_idx;
    logic                 accept;
    logic                 wr_en;
    logic [COLOR_W-1:0]   rd_data;
    t_dist                cur_dist;

    assign accept = start && !r_busy;
    assign wr_en  = accept && (i_action == ACT_WRITE)
                    && (32'(i_entry_index) < PALETTE_DEPTH);

    npcs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_entry_index[ADDR_W-1:0]),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (rd_data)
    );

    npcs_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_color (r_color),
        .i_entry (rd_data),
        .i_tag   (r_rd_tag),
        .o_dist  (cur_dist)
    );

    always_comb begin
        n_addr      = r_addr + CNT_W'(1);
        n_last      = (n_addr == r_count);
        n_take      = (cur_dist.tag.idx == '0) || (cur_dist.sum < r_best_dist);
        n_best_dist = n_take ? cur_dist.sum : r_best_dist;
        n_best_idx  = n_take ? cur_dist.tag.idx : r_best_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_issue     <= 1'b0;
            r_addr      <= '0;
            r_count     <= '0;
            r_rd_tag    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid    <= 1'b0;
            r_rd_tag.valid <= r_issue;
            r_rd_tag.last  <= n_last;
            r_rd_tag.idx   <= r_addr[ADDR_W-1:0];
            if (i_cfg_we) begin
                r_count <= (32'(i_cfg_data) > PALETTE_DEPTH) ? CNT_W'(PALETTE_DEPTH)
                                                             : CNT_W'(i_cfg_data);
            end
            if (r_issue) begin
                r_addr <= n_addr;
                if (n_last) begin
                    r_issue <= 1'b0;
                end
            end
            if (accept && (i_action == ACT_MAP)) begin
                r_addr <= '0;
                if (r_count == '0) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_busy  <= 1'b1;
                    r_issue <= 1'b1;
                end
            end
            if (cur_dist.tag.valid && cur_dist.tag.last) begin
                r_out_valid <= 1'b1;
                r_busy      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_MAP)) begin
            r_color    <= {i_red, i_green, i_blue};
            r_out_idx  <= '0;
            r_out_dist <= '0;
        end
        if (cur_dist.tag.valid) begin
            r_best_dist <= n_best_dist;
            r_best_idx  <= n_best_idx;
            if (cur_dist.tag.last) begin
                r_out_idx  <= IDX_OUT_W'(n_best_idx);
                r_out_dist <= n_best_dist;
            end
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_out_valid;
    assign o_best_index    = r_out_idx;
    assign o_best_distance = r_out_dist;

`ifndef SYNTHESIS
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_action == ACT_WRITE)) |=> (!busy && !o_valid))
        else $error("write item started a search");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_best_distance <= DIST_W'(195075)))
        else $error("distance out of range");
`endif

endmodule

### rtl/npcs_ram.sv
// ----------------------------------------------------------------------------
// npcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/npcs_dist_unit.sv
// ----------------------------------------------------------------------------
// npcs_dist_unit
// Shared two-stage squared RGB distance unit, one palette entry per cycle.
// ----------------------------------------------------------------------------
module npcs_dist_unit
    import npcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [COLOR_W-1:0] i_color,
    input  logic [COLOR_W-1:0] i_entry,
    input  t_tag               i_tag,
    output t_dist              o_dist
);

    t_tag            r_tag1;
    t_tag            r_tag2;
    logic [CH_W-1:0] r_dr;
    logic [CH_W-1:0] r_dg;
    logic [CH_W-1:0] r_db;
    logic [DIST_W-1:0] r_dist;

    logic [CH_W-1:0] n_dr;
    logic [CH_W-1:0] n_dg;
    logic [CH_W-1:0] n_db;
    logic [DIST_W-1:0] n_dist;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        n_dr = abs_diff(i_color[3*CH_W-1:2*CH_W], i_entry[3*CH_W-1:2*CH_W]);
        n_dg = abs_diff(i_color[2*CH_W-1:CH_W],   i_entry[2*CH_W-1:CH_W]);
        n_db = abs_diff(i_color[CH_W-1:0],        i_entry[CH_W-1:0]);
        n_dist = DIST_W'(32'(r_dr) * 32'(r_dr)
                       + 32'(r_dg) * 32'(r_dg)
                       + 32'(r_db) * 32'(r_db));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
        r_dr   <= n_dr;
        r_dg   <= n_dg;
        r_db   <= n_db;
        r_dist <= n_dist;
    end

    assign o_dist.tag = r_tag2;
    assign o_dist.sum = r_dist;

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nearest_palette_color_search_unit: palette writes
// and map items are sent directed and in random bursts while a shadow palette
// predicts the nearest entry and its squared distance for every map item.
// ----------------------------------------------------------------------------
module testbench;
    import npcs_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = PALETTE_DEPTH + 40;
    localparam int PHASE_ITEMS   = 67;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] idx;
        logic [DIST_W-1:0]    distance;
    } t_match;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic                 i_action      = ACT_WRITE;
    logic [7:0]           i_entry_index = '0;
    logic [CH_W-1:0]      i_red         = '0;
    logic [CH_W-1:0]      i_green       = '0;
    logic [CH_W-1:0]      i_blue        = '0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 o_valid;
    logic [IDX_OUT_W-1:0] o_best_index;
    logic [DIST_W-1:0]    o_best_distance;

    logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH];
    int unsigned        search_count = 0;
    t_match             pending_matches [$];
    int unsigned        mismatches   = 0;
    int unsigned        maps_checked = 0;
    int unsigned        writes_sent  = 0;
    int unsigned        count_writes = 0;
    int unsigned        cycle_count  = 0;
    bit                 idle_enable  = 1'b0;
    int                 burst_left   = 0;

    nearest_palette_color_search_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_best_index    (o_best_index),
        .o_best_distance (o_best_distance)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned active_entries();
        return (search_count > PALETTE_DEPTH) ? PALETTE_DEPTH : search_count;
    endfunction

    function automatic t_match find_nearest(logic [COLOR_W-1:0] color);
        t_match      best;
        int unsigned n;
        int unsigned d;
        int          dr;
        int          dg;
        int          db;
        best = '0;
        n    = active_entries();
        for (int i = 0; i < n; i++) begin
            dr = int'(color[2*CH_W +: CH_W]) - int'(palette_copy[i][2*CH_W +: CH_W]);
            dg = int'(color[CH_W +: CH_W])   - int'(palette_copy[i][CH_W +: CH_W]);
            db = int'(color[0 +: CH_W])      - int'(palette_copy[i][0 +: CH_W]);
            d  = dr * dr + dg * dg + db * db;
            if (i == 0 || d < best.distance) begin
                best.distance = DIST_W'(d);
                best.idx      = IDX_OUT_W'(i);
            end
        end
        return best;
    endfunction

    // coarse colors come from a 4-level grid, which makes equal distances common
    function automatic logic [COLOR_W-1:0] pick_color(bit coarse);
        logic [CH_W-1:0] ch [3];
        for (int c = 0; c < 3; c++) begin
            if (coarse)
                ch[c] = CH_W'($urandom_range(0, 3) * 85);
            else if ($urandom_range(0, 4) == 0)
                ch[c] = CH_W'($urandom_range(0, 1) * 255);
            else
                ch[c] = CH_W'($urandom_range(0, 255));
        end
        return {ch[0], ch[1], ch[2]};
    endfunction

    task automatic send_item(logic act, logic [7:0] slot, logic [COLOR_W-1:0] color);
        start         <= 1'b1;
        i_action      <= act;
        i_entry_index <= slot;
        i_red         <= color[2*CH_W +: CH_W];
        i_green       <= color[CH_W +: CH_W];
        i_blue        <= color[0 +: CH_W];
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (act == ACT_WRITE) begin
            palette_copy[slot] = color;
            writes_sent++;
        end else begin
            pending_matches.push_back(find_nearest(color));
        end
    endtask

    task automatic pace();
        if (idle_enable) begin
            if (burst_left <= 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        search_count = value & ((1 << CFG_W) - 1);
        count_writes++;
    endtask

    task automatic test_empty_palette();
        send_item(ACT_MAP, 8'h00, 24'h000000);
        send_item(ACT_MAP, 8'hFF, 24'hFFFFFF);
        write_count(0);
        send_item(ACT_MAP, 8'h5A, 24'h80FF01);
    endtask

    task automatic test_single_entry();
        send_item(ACT_WRITE, 8'd0, 24'hFF00FF);
        write_count(1);
        send_item(ACT_MAP, 8'h00, 24'h00FF00);
        send_item(ACT_MAP, 8'h00, 24'hFF00FF);
    endtask

    task automatic test_ties();
        send_item(ACT_WRITE, 8'd0, 24'h0A0A0A);
        send_item(ACT_WRITE, 8'd1, 24'h000000);
        send_item(ACT_WRITE, 8'd2, 24'h020202);
        write_count(3);
        send_item(ACT_MAP, 8'h00, 24'h010101);
        send_item(ACT_WRITE, 8'd2, 24'h000000);
        send_item(ACT_MAP, 8'h00, 24'h000000);
    endtask

    task automatic test_load_palette();
        idle_enable = 1'b1;
        burst_left  = 0;
        for (int i = 0; i < PALETTE_DEPTH; i++) begin
            pace();
            send_item(ACT_WRITE, 8'(i), pick_color($urandom_range(0, 1)));
        end
        idle_enable = 1'b0;
    endtask

    task automatic test_count_extremes();
        send_item(ACT_WRITE, 8'd255, 24'hFFFFFF);
        write_count(PALETTE_DEPTH);
        send_item(ACT_MAP, 8'h00, 24'hFFFFFF);
        write_count(PALETTE_DEPTH - 1);
        send_item(ACT_MAP, 8'h00, 24'hFFFFFF);
        write_count(PALETTE_DEPTH + 1);
        send_item(ACT_MAP, 8'h00, 24'hFFFFFF);
        write_count((1 << CFG_W) - 1);
        send_item(ACT_MAP, 8'hFF, 24'hFFFFFF);
        send_item(ACT_MAP, 8'h00, 24'h000000);
    endtask

    task automatic test_random_traffic();
        int unsigned phase_counts [13] = '{1, 2, 5, 17, 64, 128, 200, 255, 256,
                                           300, 511, 0, 0};
        int unsigned n;
        for (int p = 0; p < 13; p++) begin
            if (p == 12)
                phase_counts[p] = $urandom_range(0, (1 << CFG_W) - 1);
            write_count(phase_counts[p]);
            n           = active_entries();
            idle_enable = (p % 3 != 2);
            burst_left  = 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pace();
                if ($urandom_range(0, 3) == 0)
                    send_item(ACT_WRITE, 8'($urandom_range(0, 255)),
                              pick_color($urandom_range(0, 1)));
                else if (n != 0 && $urandom_range(0, 4) == 0)
                    send_item(ACT_MAP, 8'($urandom_range(0, 255)),
                              palette_copy[$urandom_range(0, n - 1)]);
                else
                    send_item(ACT_MAP, 8'($urandom_range(0, 255)),
                              pick_color($urandom_range(0, 1)));
            end
        end
        idle_enable = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_match want;
        if (i_rst_n && o_valid) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: unexpected result index %0d distance %0d",
                             o_best_index, o_best_distance);
            end else begin
                want = pending_matches.pop_front();
                maps_checked++;
                if (o_best_index !== want.idx || o_best_distance !== want.distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch index exp %0d got %0d, distance exp %0d got %0d",
                                 want.idx, o_best_index, want.distance, o_best_distance);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_palette();
        test_single_entry();
        test_ties();
        test_load_palette();
        test_count_extremes();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("tb: %0d map results checked, %0d palette writes, %0d count settings",
                 maps_checked, writes_sent, count_writes);
        $display("tb: %0d mismatches in %0d cycles", mismatches, cycle_count);
        if (mismatches == 0 && pending_matches.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
rtl/npcs_pkg.sv
rtl/npcs_ram.sv
rtl/npcs_dist_unit.sv
rtl/nearest_palette_color_search_unit.sv
test/testbench.sv
